/* rtl/fba_pkg.sv */
// fba_pkg: shared types, codes and helpers of the fragment block allocator
// used by the allocator, its counters and its checker; no dependencies
package fba_pkg;

  localparam int unsigned MaxFrags   = 32768;
  localparam int unsigned MaxInodes  = 4096;
  localparam int unsigned FmapBytes  = MaxFrags / 8;
  localparam int unsigned ImapBytes  = MaxInodes / 8;
  localparam int unsigned FmapAw     = $clog2(FmapBytes);
  localparam int unsigned ImapAw     = $clog2(ImapBytes);
  localparam int unsigned FragAw     = $clog2(MaxFrags);

  // operations
  localparam logic [2:0] OpWriteMap  = 3'd0;
  localparam logic [2:0] OpAlloc     = 3'd1;
  localparam logic [2:0] OpMarkInode = 3'd2;
  localparam logic [2:0] OpRestart   = 3'd3;
  localparam logic [2:0] OpReadRun   = 3'd4;

  // map selects
  localparam logic [1:0] MapFree    = 2'd0;
  localparam logic [1:0] MapCluster = 2'd1;
  localparam logic [1:0] MapInode   = 2'd2;

  // register indexes
  localparam logic [2:0] RegFragPerBlock = 3'd0;
  localparam logic [2:0] RegFragSizeLog2 = 3'd1;
  localparam logic [2:0] RegDataFrags    = 3'd2;
  localparam logic [2:0] RegClusterTrack = 3'd3;
  localparam logic [2:0] RegFreeBlkStart = 3'd4;
  localparam logic [2:0] RegFreeInoStart = 3'd5;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNoFree   = 2'd1,
    StNotFound = 2'd2,
    StTooBig   = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [1:0]  map_select;
    logic [11:0] map_address;
    logic [7:0]  map_data;
    logic [18:0] size_bytes;
    logic        is_directory;
    logic [11:0] inode_number;
    logic [2:0]  run_index;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [14:0] frag_address;
    logic [15:0] free_blocks;
    logic [15:0] free_frags;
    logic [15:0] dir_count;
    logic [12:0] free_inodes;
    logic [15:0] run_count;
  } out_rsp_t;

  // counter update commands from the controller
  typedef struct packed {
    logic       restart;
    logic       alloc;
    logic       is_dir;
    logic       run_inc;
    logic [2:0] trail;
    logic       inode_dec;
  } cnt_cmd_t;

  function automatic logic fpb_valid(input logic [3:0] fpb);
    return (fpb == 4'd1) || (fpb == 4'd2) || (fpb == 4'd4) || (fpb == 4'd8);
  endfunction

  // mask of one block inside a byte
  function automatic logic [7:0] blk_mask(input logic [3:0] fpb);
    logic [7:0] m;
    m = 8'h00;
    unique case (fpb)
      4'd1:    m = 8'h01;
      4'd2:    m = 8'h03;
      4'd4:    m = 8'h0f;
      4'd8:    m = 8'hff;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  function automatic logic [1:0] fpb_log2(input logic [3:0] fpb);
    logic [1:0] l;
    l = 2'd0;
    unique case (fpb)
      4'd2:    l = 2'd1;
      4'd4:    l = 2'd2;
      4'd8:    l = 2'd3;
      default: l = 2'd0;
    endcase
    return l;
  endfunction

endpackage

/* rtl/fragment_block_allocator.sv */
// fragment_block_allocator: first-fit block allocator over a free-fragment
// bitmap, a cluster bitmap and an inode bitmap held in synchronous rams.
// One request is worked on at a time and every request gives one response.
// Map writes, restarts, run-count reads and allocations refused before the
// scan go from dispatch straight to the response; inode marks add a
// read-modify-write of the inode map. An allocation scans the free map byte
// by byte, each byte read from ram and then checked, over at most the 4096
// bytes of the map, and adds a read-modify-write of the cluster map when
// cluster tracking is on. A response held by out_stall_i delays the next
// request. Map contents are undefined after reset and must be loaded before
// use. Depends on fba_pkg, fba_ram, fba_counters.
module fragment_block_allocator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fba_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fba_pkg::out_rsp_t out_rsp_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDisp = 3'd1;
  localparam logic [2:0] StSrd  = 3'd2;
  localparam logic [2:0] StSchk = 3'd3;
  localparam logic [2:0] StCwr  = 3'd4;
  localparam logic [2:0] StIwr  = 3'd5;
  localparam logic [2:0] StDone = 3'd6;

  // configuration registers
  logic [3:0]  fpb_q, fsl_q;
  logic [15:0] data_frags_q, fblk_start_q;
  logic        ctrack_q;
  logic [12:0] fino_start_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fpb_q        <= 4'd8;
      fsl_q        <= 4'd11;
      data_frags_q <= 16'd32768;
      ctrack_q     <= 1'b0;
      fblk_start_q <= '0;
      fino_start_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fba_pkg::RegFragPerBlock: fpb_q        <= cfg_data_i[3:0];
        fba_pkg::RegFragSizeLog2: fsl_q        <= cfg_data_i[3:0];
        fba_pkg::RegDataFrags:    data_frags_q <= cfg_data_i;
        fba_pkg::RegClusterTrack: ctrack_q     <= cfg_data_i[0];
        fba_pkg::RegFreeBlkStart: fblk_start_q <= cfg_data_i;
        fba_pkg::RegFreeInoStart: fino_start_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // control state
  logic [2:0]  state_q, state_d;
  logic        out_valid_q, out_valid_d;
  fba_pkg::in_req_t  req_q;
  fba_pkg::out_rsp_t rsp_q;
  logic [1:0]  status_q, status_d;
  logic [14:0] addr_q, addr_d;
  logic [11:0] scan_q, scan_d;
  logic [14:0] blk_q, blk_d;
  logic        in_acc, out_free;

  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // request size decode
  logic [19:0] fsize, bsize, need_raw;
  logic [3:0]  need;
  logic [15:0] limit;
  logic [7:0]  bmask, cmask;
  logic [2:0]  trail;

  assign fsize    = 20'd1 << fsl_q;
  assign bsize    = {16'd0, fpb_q} << fsl_q;
  assign need_raw = ({1'b0, req_q.size_bytes} + fsize - 20'd1) >> fsl_q;
  assign need     = (need_raw == 20'd0) ? 4'd1 : need_raw[3:0];
  assign limit    = (data_frags_q > 16'd32768) ? 16'd32768 : data_frags_q;
  assign bmask    = fba_pkg::blk_mask(fpb_q);
  // claimed fragments: the needed ones; trailing ones stay free
  assign cmask    = 8'((9'd1 << need) - 9'd1);
  assign trail    = 3'(fpb_q - need);

  // memories
  logic        fm_we, cm_we, im_we;
  logic [11:0] fm_waddr, cm_waddr, fm_raddr, cm_raddr;
  logic [8:0]  im_waddr, im_raddr;
  logic [7:0]  fm_wdata, cm_wdata, im_wdata, fm_rdata, cm_rdata, im_rdata;

  fba_ram #(.Depth(fba_pkg::FmapBytes), .Dw(8)) u_free_map (
    .clk_i, .we_i(fm_we), .waddr_i(fm_waddr), .wdata_i(fm_wdata),
    .raddr_i(fm_raddr), .rdata_o(fm_rdata)
  );
  fba_ram #(.Depth(fba_pkg::FmapBytes), .Dw(8)) u_cluster_map (
    .clk_i, .we_i(cm_we), .waddr_i(cm_waddr), .wdata_i(cm_wdata),
    .raddr_i(cm_raddr), .rdata_o(cm_rdata)
  );
  fba_ram #(.Depth(fba_pkg::ImapBytes), .Dw(8)) u_inode_map (
    .clk_i, .we_i(im_we), .waddr_i(im_waddr), .wdata_i(im_wdata),
    .raddr_i(im_raddr), .rdata_o(im_rdata)
  );

  // counters
  fba_pkg::cnt_cmd_t cmd;
  logic [15:0] free_blocks, loose_frags, dir_count, run_val;
  logic [12:0] free_inodes;

  fba_counters u_counters (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .free_blk_start_i(fblk_start_q), .free_ino_start_i(fino_start_q),
    .run_sel_i(req_q.run_index),
    .free_blocks_o(free_blocks), .loose_frags_o(loose_frags),
    .dir_count_o(dir_count), .free_inodes_o(free_inodes),
    .run_count_o(run_val)
  );

  // first fully free block inside the byte just read
  logic       hit;
  logic [2:0] hit_off;
  logic [14:0] hit_frag;
  logic [15:0] next_start;

  always_comb begin
    logic [7:0]  m;
    logic [14:0] d;
    hit     = 1'b0;
    hit_off = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      m = bmask << k;
      d = {scan_q, 3'(k)};
      if ((3'(k) & 3'(fpb_q - 4'd1)) == 3'd0 && {1'b0, d} < limit &&
          (fm_rdata & m) == m) begin
        hit     = 1'b1;
        hit_off = 3'(k);
      end
    end
  end

  assign hit_frag   = {scan_q, hit_off};
  assign next_start = {({1'b0, scan_q} + 13'd1), 3'd0};

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    addr_d   = addr_q;
    scan_d   = scan_q;
    blk_d    = blk_q;
    cmd      = '0;
    fm_we    = 1'b0;
    cm_we    = 1'b0;
    im_we    = 1'b0;
    fm_waddr = req_q.map_address;
    cm_waddr = req_q.map_address;
    im_waddr = req_q.map_address[8:0];
    fm_wdata = req_q.map_data;
    cm_wdata = req_q.map_data;
    im_wdata = req_q.map_data;
    fm_raddr = scan_q;
    cm_raddr = blk_d[14:3];
    im_raddr = req_q.inode_number[11:3];
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d  = StDisp;
          status_d = fba_pkg::StOk;
          addr_d   = '0;
          scan_d   = '0;
        end
      end
      StDisp: begin
        state_d = StDone;
        unique case (req_q.operation)
          fba_pkg::OpWriteMap: begin
            fm_we = (req_q.map_select == fba_pkg::MapFree);
            cm_we = (req_q.map_select == fba_pkg::MapCluster);
            im_we = (req_q.map_select == fba_pkg::MapInode) &&
                    (req_q.map_address[11:9] == 3'd0);
          end
          fba_pkg::OpAlloc: begin
            priority if (free_blocks == 16'd0) begin
              status_d = fba_pkg::StNoFree;
            end else if (!fba_pkg::fpb_valid(fpb_q)) begin
              status_d = fba_pkg::StNotFound;
            end else if (need_raw > {16'd0, fpb_q}) begin
              status_d = fba_pkg::StTooBig;
            end else begin
              state_d = StSrd;
            end
          end
          fba_pkg::OpMarkInode: begin
            cmd.inode_dec = 1'b1;
            state_d       = StIwr;
          end
          fba_pkg::OpRestart: cmd.restart = 1'b1;
          default: ;
        endcase
      end
      StSrd: state_d = StSchk;
      StSchk: begin
        priority if (hit) begin
          fm_we    = 1'b1;
          fm_waddr = scan_q;
          fm_wdata = fm_rdata & ~(cmask << hit_off);
          addr_d   = hit_frag;
          blk_d    = hit_frag >> fba_pkg::fpb_log2(fpb_q);
          // fetch the cluster byte of the new block for the next cycle
          cm_raddr = blk_d[14:3];
          cmd.alloc  = 1'b1;
          cmd.is_dir = req_q.is_directory;
          // a full-size request leaves no trail and no run count
          if ({1'b0, req_q.size_bytes} != bsize) begin
            cmd.trail   = trail;
            cmd.run_inc = 1'b1;
          end else begin
            cmd.trail = 3'd0;
          end
          state_d = ctrack_q ? StCwr : StDone;
        end else if (next_start >= limit) begin
          status_d = fba_pkg::StNotFound;
          state_d  = StDone;
        end else begin
          scan_d  = scan_q + 12'd1;
          state_d = StSrd;
        end
      end
      StCwr: begin
        cm_we    = 1'b1;
        cm_waddr = blk_q[14:3];
        cm_wdata = cm_rdata & ~(8'd1 << blk_q[2:0]);
        state_d  = StDone;
      end
      StIwr: begin
        im_we    = 1'b1;
        im_waddr = req_q.inode_number[11:3];
        im_wdata = im_rdata | (8'd1 << req_q.inode_number[2:0]);
        state_d  = StDone;
      end
      StDone: begin
        if (out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign out_valid_d = (state_q == StDone) ? 1'b1 :
                       (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q != StDone || out_free) out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) req_q <= in_req_i;
    status_q <= status_d;
    addr_q   <= addr_d;
    scan_q   <= scan_d;
    blk_q    <= blk_d;
    if (state_q == StDone && out_free) begin
      rsp_q.status       <= status_q;
      rsp_q.frag_address <= (status_q == fba_pkg::StOk) ? addr_q : 15'd0;
      rsp_q.free_blocks  <= free_blocks;
      rsp_q.free_frags   <= loose_frags;
      rsp_q.dir_count    <= dir_count;
      rsp_q.free_inodes  <= free_inodes;
      rsp_q.run_count    <= (req_q.operation == fba_pkg::OpReadRun) ? run_val : 16'd0;
    end
  end

endmodule

/* rtl/fba_ram.sv */
// fba_ram: generic synchronous ram, one write and one read port
// registered read data; no dependencies
module fba_ram #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned Aw    = $clog2(Depth),
  parameter int unsigned Dw    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  logic [Dw-1:0] wdata_i,
  input  logic [Aw-1:0] raddr_i,
  output logic [Dw-1:0] rdata_o
);

  logic [Dw-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

/* rtl/fba_counters.sv */
// fba_counters: summary counters and free run histogram
// depends on fba_pkg
module fba_counters (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fba_pkg::cnt_cmd_t  cmd_i,
  input  logic [15:0]        free_blk_start_i,
  input  logic [12:0]        free_ino_start_i,
  input  logic [2:0]         run_sel_i,
  output logic [15:0]        free_blocks_o,
  output logic [15:0]        loose_frags_o,
  output logic [15:0]        dir_count_o,
  output logic [12:0]        free_inodes_o,
  output logic [15:0]        run_count_o
);

  logic [15:0] free_blk_q, loose_q, dir_q;
  logic [12:0] free_ino_q;
  logic [15:0] runs_q [8];
  logic [2:0]  run_addr;
  logic [16:0] loose_sum;

  // single read port into the histogram
  assign run_addr    = cmd_i.alloc ? cmd_i.trail : run_sel_i;
  assign run_count_o = runs_q[run_addr];
  assign loose_sum   = {1'b0, loose_q} + {14'd0, cmd_i.trail};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_blk_q <= '0;
      loose_q    <= '0;
      dir_q      <= '0;
      free_ino_q <= '0;
      for (int i = 0; i < 8; i++) runs_q[i] <= '0;
    end else if (cmd_i.restart) begin
      free_blk_q <= free_blk_start_i;
      free_ino_q <= free_ino_start_i;
      loose_q    <= '0;
      dir_q      <= '0;
      for (int i = 0; i < 8; i++) runs_q[i] <= '0;
    end else begin
      if (cmd_i.alloc) begin
        free_blk_q <= free_blk_q - 16'd1;
        if (cmd_i.is_dir && dir_q != 16'hffff) dir_q <= dir_q + 16'd1;
        loose_q <= loose_sum[16] ? 16'hffff : loose_sum[15:0];
        if (cmd_i.run_inc && runs_q[run_addr] != 16'hffff) begin
          runs_q[run_addr] <= runs_q[run_addr] + 16'd1;
        end
      end
      if (cmd_i.inode_dec && free_ino_q != 13'd0) free_ino_q <= free_ino_q - 13'd1;
    end
  end

  assign free_blocks_o = free_blk_q;
  assign loose_frags_o = loose_q;
  assign dir_count_o   = dir_q;
  assign free_inodes_o = free_ino_q;

endmodule

/* rtl/fba_checker.sv */
// fba_checker: port-level checks of the fragment block allocator
// depends on fba_pkg; bound to fragment_block_allocator
module fba_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input fba_pkg::in_req_t  in_req_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input fba_pkg::out_rsp_t out_rsp_o
);

  // one request in flight: taking a request stalls the input next cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while another is in work");

  // a held response keeps its payload
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled response changed");

  // failed allocations report no fragment
  a_err_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status != fba_pkg::StOk |-> out_rsp_o.frag_address == 15'd0)
    else $error("error response with fragment address");

endmodule

bind fragment_block_allocator fba_checker u_fba_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_req_i,
  .out_valid_o, .out_stall_i, .out_rsp_o
);
